### sv/bkst_pkg.sv
// Package for the bounded key set table: operation and status codes, controller
// states, the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package bkst_pkg;

  // Fixed field widths of the stream and register payloads.
  localparam int KEY_W       = 8;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int LIMIT_W     = 7;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;

  // Reset value of the key limit register.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // Register index of the key limit register (paddr bit 2).
  localparam logic REG_IDX_KEY_LIMIT = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_DUP      = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the request and register the match vector
    logic execute;  // apply the operation and load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register empty or being taken this cycle
  } dp_sts_t;

endpackage

### sv/bkst_ctrl.sv
// Controller of the bounded key set table: a two-state machine that takes a
// request, then applies it once the result register is free. Uses bkst_pkg.
`timescale 1ns / 1ps

module bkst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  bkst_pkg::dp_sts_t sts_i,
  output bkst_pkg::dp_cmd_t cmd_o
);
  import bkst_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a request moves to execute, execute waits for the result slot.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs: ready in idle, execute once the result register can take a result.
  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      S_EXEC: begin
        cmd_o.execute = sts_i.out_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### sv/bkst_datapath.sv
// Datapath of the bounded key set table: the packed key entries, the count,
// the parallel match vector, the compaction shift and the result register. Uses bkst_pkg.
`timescale 1ns / 1ps

module bkst_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bkst_pkg::dp_cmd_t                    cmd_i,
  output bkst_pkg::dp_sts_t                    sts_o,
  input  logic [bkst_pkg::KIND_W-1:0]          kind_i,
  input  logic [bkst_pkg::KEY_W-1:0]           key_i,
  input  logic [bkst_pkg::LIMIT_W-1:0]         key_limit_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output logic [bkst_pkg::STATUS_W-1:0]        status_o,
  output logic                                 was_present_o,
  output logic [bkst_pkg::COUNT_OUT_W-1:0]     count_o
);
  import bkst_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [KEY_W-1:0]    entries_q [CAPACITY];
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CAPACITY-1:0] match_q, match_d;
  logic [CAPACITY-1:0] shift_en;
  kind_e               kind_q;
  logic [KEY_W-1:0]    key_q;

  logic                present;
  logic                do_ins, do_rem, do_clr;
  status_e             status_d;

  logic                res_valid_q, res_valid_d;
  status_e             status_q;
  logic                present_q;
  logic [CNT_W-1:0]    res_count_q;

  // Parallel compare of the incoming key against every valid entry.
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      match_d[j] = (CNT_W'(j) < count_q) && (entries_q[j] == key_i);
    end
  end

  // Request and match vector capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_e'(kind_i);
      key_q   <= key_i;
      match_q <= match_d;
    end
  end

  // Operation decode; keys are distinct, so at most one match bit is set.
  always_comb begin
    present  = |match_q;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_clr   = 1'b0;
    status_d = ST_DONE;
    case (kind_q)
      KIND_INSERT: begin
        if (present) begin
          status_d = ST_DUP;
        end else if ((key_q >= {1'b0, key_limit_i}) ||
                     (count_q >= CNT_W'(CAPACITY))) begin
          status_d = ST_RANGE;
        end else begin
          do_ins = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (present) begin
          do_rem = 1'b1;
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      KIND_LOOKUP: begin
        status_d = present ? ST_DONE : ST_NOTFOUND;
      end
      KIND_CLEAR: begin
        do_clr = 1'b1;
      end
      default: status_d = ST_DONE;
    endcase
  end

  // Count update.
  always_comb begin
    count_d = count_q;
    if (do_clr) begin
      count_d = '0;
    end else if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  // Entry row: each entry shifts down from its upper neighbour when it lies at
  // or above the removed position, or takes the key when it is the next free slot.
  for (genvar J = 0; J < CAPACITY; J++) begin : g_entry
    localparam logic [CAPACITY-1:0] LOW_MASK = {CAPACITY{1'b1}} >> (CAPACITY - 1 - J);

    assign shift_en[J] = |(match_q & LOW_MASK);

    if (J < CAPACITY - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (cmd_i.execute) begin
          if (do_rem && shift_en[J]) begin
            entries_q[J] <= entries_q[J+1];
          end else if (do_ins && (CNT_W'(J) == count_q)) begin
            entries_q[J] <= key_q;
          end
        end
      end
    end else begin : g_last
      // The top entry drops out of the valid range on a remove, so it keeps its value.
      always_ff @(posedge clk_i) begin
        if (cmd_i.execute && do_ins && (CNT_W'(J) == count_q)) begin
          entries_q[J] <= key_q;
        end
      end
    end
  end

  // Result register: filled on execute, emptied when the consumer takes it.
  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_i.execute) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      status_q    <= status_d;
      present_q   <= do_clr ? 1'b0 : present;
      res_count_q <= count_d;
    end
  end

  assign sts_o.out_free = !res_valid_q || res_ready_i;
  assign res_valid_o    = res_valid_q;
  assign status_o       = status_q;
  assign was_present_o  = present_q;
  assign count_o        = COUNT_OUT_W'(res_count_q);

endmodule

### sv/bounded_key_set_table.sv
// Top level of the bounded key set table: stream ports, the APB key limit
// register, and the controller and datapath. Uses bkst_pkg, bkst_ctrl, bkst_datapath.
`timescale 1ns / 1ps

// Channel        Direction  Payload
// s_axis_*       in         request: tuser kind, tdata key
// m_axis_*       out        result: tdata status, was_present, count
// APB            in/out     key_limit register at byte address 0
//
// Each request has an accept step and then an execute step: on acceptance the key is
// compared with every valid entry at once and the match vector is registered; in the
// execute step the operation is applied and the result register is loaded.
// The execute cycle waits while the result register holds a result not yet taken.
// Reset empties the set at once and sets key_limit to 64.

module bounded_key_set_table #(
  parameter int CAPACITY = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bkst_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] key
  input  logic [bkst_pkg::KIND_W-1:0]     s_axis_tuser,   // [1:0] kind
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bkst_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [1:0] status, [2] was_present,
                                                          // [9:3] count, [15:10] zero
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bkst_pkg::ADDR_W-1:0]     paddr,
  input  logic [bkst_pkg::DATA_W-1:0]     pwdata,
  output logic [bkst_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import bkst_pkg::*;

  logic [LIMIT_W-1:0]     key_limit_q;
  dp_cmd_t                cmd;
  dp_sts_t                sts;
  logic [STATUS_W-1:0]    status;
  logic                   was_present;
  logic [COUNT_OUT_W-1:0] count;

  // Configuration register write.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_KEY_LIMIT)) begin
      key_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // Register read back.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDX_KEY_LIMIT) begin
      prdata = {{(DATA_W - LIMIT_W){1'b0}}, key_limit_q};
    end
  end

  bkst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bkst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (s_axis_tuser),
    .key_i         (s_axis_tdata[KEY_W-1:0]),
    .key_limit_i   (key_limit_q),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .status_o      (status),
    .was_present_o (was_present),
    .count_o       (count)
  );

  // Result packing, status in the lowest bits.
  assign m_axis_tdata = {{(OUT_DATA_W - STATUS_W - 1 - COUNT_OUT_W){1'b0}},
                         count, was_present, status};

endmodule

### verif/testbench.sv
// Self-checking testbench for bounded_key_set_table: drives insert, remove, lookup and
// clear requests over the stream ports and key limits over APB, and checks every result.
// Depends on bkst_pkg and bounded_key_set_table.
`timescale 1ns / 1ps

module testbench;
  import bkst_pkg::*;

  localparam int SET_CAPACITY     = 64;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int LONG_HOLD_AFTER  = 500;
  localparam int PHASE_ITEMS      = 210;
  localparam int MAX_PRINTED      = 40;

  localparam logic [ADDR_W-1:0] LIMIT_ADDR = {REG_IDX_KEY_LIMIT, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_IDX_KEY_LIMIT, 2'b00};

  // Receiver stall patterns.
  localparam int RX_ALWAYS  = 0;
  localparam int RX_COIN    = 1;
  localparam int RX_SPARSE  = 2;
  localparam int RX_PATTERN = 3;

  // Ready pattern used by the patterned receiver mode, one bit per cycle.
  localparam logic [7:0] RX_STALL_BITS = 8'b1011_0010;

  typedef struct {
    kind_e            kind;
    logic [KEY_W-1:0] key;
  } set_request_t;

  typedef struct {
    status_e                status;
    logic                   was_present;
    logic [COUNT_OUT_W-1:0] count;
  } set_outcome_t;

  // Clock, reset and DUT ports; every input starts at a known value.
  logic                  clk     = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_key   = '0;
  logic [KIND_W-1:0]     s_kind  = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [ADDR_W-1:0]     paddr   = '0;
  logic [DATA_W-1:0]     pwdata  = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  always #2 clk = ~clk;

  bounded_key_set_table #(
    .CAPACITY(SET_CAPACITY)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_key),
    .s_axis_tuser (s_kind),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Predicted contents of the set and the key limit as the block should hold them.
  logic [KEY_W-1:0]   model_keys [SET_CAPACITY];
  int                 model_size  = 0;
  logic [LIMIT_W-1:0] model_limit = LIMIT_RESET;

  set_request_t queued_requests[$];
  set_outcome_t pending_outcomes[$];

  int error_count    = 0;
  int requests_sent  = 0;
  int results_taken  = 0;
  int limit_writes   = 0;
  int full_rejects   = 0;
  int op_seen[4]     = '{default: 0};
  int status_seen[4] = '{default: 0};

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Apply one request to the predicted set and queue the result it should give.
  task automatic predict_set_op(input set_request_t rq);
    int           pos;
    set_outcome_t res;
    pos             = -1;
    res.status      = ST_DONE;
    res.was_present = 1'b0;
    if (rq.kind == KIND_CLEAR) begin
      model_size = 0;
    end else begin
      for (int i = 0; i < model_size; i++) begin
        if (pos < 0 && model_keys[i] == rq.key) pos = i;
      end
      res.was_present = (pos >= 0);
      case (rq.kind)
        KIND_INSERT: begin
          if (res.was_present) begin
            res.status = ST_DUP;
          end else if (rq.key >= model_limit || model_size >= SET_CAPACITY) begin
            res.status = ST_RANGE;
            if (rq.key < model_limit) full_rejects++;
          end else begin
            model_keys[model_size] = rq.key;
            model_size++;
          end
        end
        KIND_REMOVE: begin
          if (!res.was_present) begin
            res.status = ST_NOTFOUND;
          end else begin
            // Close the gap so the valid entries stay packed.
            for (int j = pos; j + 1 < model_size; j++) model_keys[j] = model_keys[j + 1];
            model_size--;
          end
        end
        default: begin
          res.status = res.was_present ? ST_DONE : ST_NOTFOUND;
        end
      endcase
    end
    res.count = COUNT_OUT_W'(model_size);
    op_seen[rq.kind]++;
    status_seen[res.status]++;
    pending_outcomes.push_back(res);
  endtask

  // Random request: mostly keys near the limit or in a small pool so that hits are common.
  function automatic set_request_t random_request(input int lim, input int clear_pct);
    set_request_t rq;
    int           r;
    int           top;
    r = $urandom_range(0, 99);
    if (r < clear_pct) rq.kind = KIND_CLEAR;
    else if (r < clear_pct + 45) rq.kind = KIND_INSERT;
    else if (r < clear_pct + 68) rq.kind = KIND_REMOVE;
    else rq.kind = KIND_LOOKUP;
    top = (lim + 2 > 255) ? 255 : lim + 2;
    r   = $urandom_range(0, 99);
    if (r < 15) rq.key = KEY_W'($urandom_range(0, 255));
    else if (r < 40) rq.key = KEY_W'($urandom_range(0, 15));
    else rq.key = KEY_W'($urandom_range(0, top));
    return rq;
  endfunction

  task automatic push_req(input kind_e kind, input int key);
    set_request_t rq;
    rq.kind = kind;
    rq.key  = KEY_W'(key);
    queued_requests.push_back(rq);
  endtask

  // Wait until every queued request has gone in and every result has come out.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (queued_requests.size() != 0 || s_valid || pending_outcomes.size() != 0);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LIMIT_ADDR) model_limit = data[LIMIT_W-1:0];
    limit_writes++;
  endtask

  task automatic check_limit_readback();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[LIMIT_W-1:0] !== model_limit)
      report_error($sformatf("key limit read back as %0d, expected %0d",
                             prdata[LIMIT_W-1:0], model_limit));
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Request sender: bursts of random length separated by random gaps.
  set_request_t drv_req;
  int           burst_left = 1;
  int           gap_left   = 0;

  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_key   <= '0;
      s_kind  <= '0;
    end else begin
      if (s_valid && s_ready) begin
        predict_set_op(drv_req);
        requests_sent++;
      end
      if (!s_valid || s_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          drv_req = queued_requests.pop_front();
          s_valid <= 1'b1;
          s_key   <= drv_req.key;
          s_kind  <= drv_req.kind;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: switches among random stall patterns, with one long hold-off.
  int rx_cycle       = 0;
  int rx_mode        = RX_ALWAYS;
  int hold_left      = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 50 == 0) rx_mode = $urandom_range(RX_ALWAYS, RX_PATTERN);
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (!long_hold_done && results_taken >= LONG_HOLD_AFTER) begin
        hold_left      = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
        m_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: m_ready <= 1'b1;
          RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
          default:   m_ready <= RX_STALL_BITS[rx_cycle[2:0]];
        endcase
      end
    end
  end

  // Result checker: compares each result with the oldest prediction.
  set_outcome_t want;

  always @(posedge clk) begin
    if (rst_ni && m_valid && m_ready) begin
      results_taken++;
      if (pending_outcomes.size() == 0) begin
        report_error($sformatf("result 0x%04h arrived with no request outstanding", m_data));
      end else begin
        want = pending_outcomes.pop_front();
        if (m_data[1:0] !== want.status)
          report_error($sformatf("result %0d: status %0d, expected %0d",
                                 results_taken, m_data[1:0], want.status));
        if (m_data[2] !== want.was_present)
          report_error($sformatf("result %0d: was_present %0b, expected %0b",
                                 results_taken, m_data[2], want.was_present));
        if (m_data[9:3] !== want.count)
          report_error($sformatf("result %0d: count %0d, expected %0d",
                                 results_taken, m_data[9:3], want.count));
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_outcomes.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Main sequence: directed phases, then random phases under several key limits.
  initial begin : main_seq
    int phase_limit[7];
    int phase_clear[7];
    phase_limit = '{64, 1, 127, 0, 127, 0, 64};
    phase_clear = '{5, 8, 1, 4, 2, 6, 5};

    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);
    check_limit_readback();

    // Empty set, range edges at the reset limit, duplicates and shifting removes.
    push_req(KIND_LOOKUP, 9);
    push_req(KIND_REMOVE, 9);
    push_req(KIND_CLEAR, 0);
    push_req(KIND_INSERT, 0);
    push_req(KIND_INSERT, 63);
    push_req(KIND_INSERT, 64);
    push_req(KIND_INSERT, 255);
    push_req(KIND_INSERT, 0);
    push_req(KIND_LOOKUP, 0);
    push_req(KIND_LOOKUP, 63);
    push_req(KIND_LOOKUP, 255);
    push_req(KIND_INSERT, 5);
    push_req(KIND_INSERT, 6);
    push_req(KIND_INSERT, 7);
    push_req(KIND_REMOVE, 0);
    push_req(KIND_REMOVE, 0);
    push_req(KIND_LOOKUP, 7);
    push_req(KIND_REMOVE, 63);
    push_req(KIND_LOOKUP, 6);
    push_req(KIND_CLEAR, 8'hAA);
    push_req(KIND_LOOKUP, 5);
    push_req(KIND_INSERT, 40);
    push_req(KIND_INSERT, 50);
    push_req(KIND_INSERT, 41);
    wait_until_idle();

    // Limit of 1: stored keys stay, duplicate wins over range, remove ignores the limit.
    apb_write(LIMIT_ADDR, 32'd1);
    check_limit_readback();
    push_req(KIND_LOOKUP, 40);
    push_req(KIND_INSERT, 40);
    push_req(KIND_INSERT, 41);
    push_req(KIND_REMOVE, 50);
    push_req(KIND_INSERT, 30);
    push_req(KIND_INSERT, 1);
    push_req(KIND_INSERT, 0);
    push_req(KIND_INSERT, 0);
    push_req(KIND_CLEAR, 8'hFF);
    wait_until_idle();

    // A write to the unused register address must leave the limit alone.
    apb_write(SPARE_ADDR, 32'hFFFF_FF55);
    check_limit_readback();
    push_req(KIND_INSERT, 1);
    push_req(KIND_INSERT, 0);
    wait_until_idle();

    // Limit above the capacity: fill the table and insert into it while full.
    apb_write(LIMIT_ADDR, 32'd127);
    check_limit_readback();
    push_req(KIND_CLEAR, 0);
    for (int k = 126; k >= 63; k--) push_req(KIND_INSERT, k);
    push_req(KIND_INSERT, 0);
    push_req(KIND_INSERT, 126);
    push_req(KIND_LOOKUP, 63);
    push_req(KIND_REMOVE, 100);
    push_req(KIND_INSERT, 0);
    push_req(KIND_INSERT, 1);
    push_req(KIND_CLEAR, 0);
    wait_until_idle();

    // Random phases; the sender waits for every result before each limit change.
    for (int p = 0; p < 7; p++) begin
      apb_write(LIMIT_ADDR, (phase_limit[p] == 0) ? $urandom_range(2, 126) : phase_limit[p]);
      check_limit_readback();
      for (int n = 0; n < PHASE_ITEMS; n++)
        queued_requests.push_back(random_request(model_limit, phase_clear[p]));
      wait_until_idle();
    end

    repeat (20) @(posedge clk);
    if (pending_outcomes.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_outcomes.size()));

    $display("Covered %0d requests (insert %0d, remove %0d, lookup %0d, clear %0d), %0d results",
             requests_sent, op_seen[KIND_INSERT], op_seen[KIND_REMOVE],
             op_seen[KIND_LOOKUP], op_seen[KIND_CLEAR], results_taken);
    $display("Status mix %0d/%0d/%0d/%0d, %0d full-table rejects, %0d register writes, %0d errors",
             status_seen[ST_DONE], status_seen[ST_DUP], status_seen[ST_RANGE],
             status_seen[ST_NOTFOUND], full_rejects, limit_writes, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
